// File: hdl/rwl_pkg.sv
package rwl_pkg;

  localparam int NUM_LOCKS  = 16;
  localparam int ID_BITS    = $clog2(NUM_LOCKS);
  localparam int COUNT_BITS = 8;
  localparam int EPOCH_BITS = 16;
  localparam int ACT_BITS   = 3;
  localparam int STAT_BITS  = 2;

  localparam logic [COUNT_BITS-1:0] CNT_ALL = '1;

  typedef enum logic [ACT_BITS-1:0] {
    ACT_RD_ACQ = 3'd0,
    ACT_WR_ACQ = 3'd1,
    ACT_RD_REL = 3'd2,
    ACT_WR_REL = 3'd3,
    ACT_RD_TMO = 3'd4,
    ACT_WR_TMO = 3'd5
  } action_t;

  typedef enum logic [STAT_BITS-1:0] {
    ST_OK      = 2'd0,
    ST_WAIT    = 2'd1,
    ST_INVALID = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_t;

  typedef struct packed {
    logic                  ww;
    logic                  rw;
    logic [COUNT_BITS-1:0] cnt;
    logic [EPOCH_BITS-1:0] epoch;
  } lock_state_t;

  typedef struct packed {
    lock_state_t nxt;
    status_t     status;
    logic        wake_r;
    logic        wake_w;
  } lock_upd_t;

endpackage

// File: hdl/reader_writer_lock_table_top.sv
// table of reader-writer locks, one lock word per request
// input channel: in_valid/in_stall carry action and lock_id; a word is taken
// when in_valid is high and in_stall low
// output channel: out_valid/out_stall carry status, wake pulses, the lock's
// epoch and its state after the update
// lock state sits in one synchronous ram; the entry is read when a word is
// taken, then updated and written back when the update stage fires
// out_valid rises once the update stage hands its word to the output register
// throughput: one word per cycle while out_stall is low, set by the single
// ram read-modify-write; a write-back to the same lock as the next word is
// forwarded from a copy of the last written entry
// when out_stall holds the output register the update stage waits, and
// in_stall rises once that stage is also full
// reset (rst, synchronous) clears the per-entry valid flags, so every lock
// reads as free with epoch zero; no clearing pass is needed
module reader_writer_lock_table_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rwl_pkg::ACT_BITS-1:0]  action,
  input  logic [rwl_pkg::ID_BITS-1:0]   lock_id,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rwl_pkg::STAT_BITS-1:0] status,
  output logic                          rd_wake,
  output logic                          wr_wake,
  output logic [rwl_pkg::EPOCH_BITS-1:0] writer_epoch,
  output logic [rwl_pkg::COUNT_BITS-1:0] reader_count,
  output logic                          write_locked,
  output logic                          readers_waiting,
  output logic                          writers_waiting
);
  import rwl_pkg::*;

  lock_state_t mem [NUM_LOCKS];
  logic [NUM_LOCKS-1:0] vbits;

  lock_state_t           rd_q;
  lock_state_t           last;
  lock_state_t           cur;
  lock_upd_t             upd;
  logic                  s2_valid;
  logic [ID_BITS-1:0]    s2_id;
  logic [ACT_BITS-1:0]   s2_act;
  logic                  s2_fwd;
  logic                  s2_vld;
  logic                  s2_fire;
  logic                  in_acc;

  assign s2_fire  = s2_valid && (!out_valid || !out_stall);
  assign in_stall = s2_valid && !s2_fire;
  assign in_acc   = in_valid && !in_stall;

  // never-written entries read as a free lock
  always_comb begin
    if (s2_fwd) begin
      cur = last;
    end else if (s2_vld) begin
      cur = rd_q;
    end else begin
      cur = '0;
    end
  end

  rwl_update u_update (
    .action (s2_act),
    .cur    (cur),
    .upd    (upd)
  );

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_q <= mem[lock_id];
    end
    if (s2_fire) begin
      mem[s2_id] <= upd.nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
      vbits     <= '0;
    end else begin
      if (in_acc) begin
        s2_valid <= 1'b1;
      end else if (s2_fire) begin
        s2_valid <= 1'b0;
      end
      if (s2_fire) begin
        out_valid    <= 1'b1;
        vbits[s2_id] <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s2_id  <= lock_id;
      s2_act <= action;
      // ram read races the write-back of the same lock
      s2_fwd <= s2_fire && (s2_id == lock_id);
      s2_vld <= vbits[lock_id];
    end
    if (s2_fire) begin
      last            <= upd.nxt;
      status          <= upd.status;
      rd_wake         <= upd.wake_r;
      wr_wake         <= upd.wake_w;
      writer_epoch    <= upd.nxt.epoch;
      reader_count    <= (upd.nxt.cnt == CNT_ALL) ? '0 : upd.nxt.cnt;
      write_locked    <= (upd.nxt.cnt == CNT_ALL);
      readers_waiting <= upd.nxt.rw;
      writers_waiting <= upd.nxt.ww;
    end
  end

  a_stall_needs_busy_stage: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s2_valid && out_valid && out_stall))
    else $error("input stalled without a blocked update stage");

  a_entry_marked_written: assert property (@(posedge clk) disable iff (rst)
    s2_fire |=> vbits[$past(s2_id)])
    else $error("written lock entry not marked valid");

  a_locked_has_no_readers: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(write_locked && (reader_count != '0)))
    else $error("write locked result reports readers");

  a_wait_without_wake: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_WAIT)) |-> (!rd_wake && !wr_wake))
    else $error("must-wait result carries a wake");

endmodule

// File: hdl/rwl_update.sv
module rwl_update (
  input  logic [rwl_pkg::ACT_BITS-1:0] action,
  input  rwl_pkg::lock_state_t         cur,
  output rwl_pkg::lock_upd_t           upd
);
  import rwl_pkg::*;

  logic wlocked;

  assign wlocked = (cur.cnt == CNT_ALL);

  always_comb begin
    upd.nxt    = cur;
    upd.status = ST_OK;
    upd.wake_r = 1'b0;
    upd.wake_w = 1'b0;
    case (action)
      ACT_RD_ACQ: begin
        if (!cur.ww && (cur.cnt < (CNT_ALL - COUNT_BITS'(1)))) begin
          upd.nxt.cnt = cur.cnt + COUNT_BITS'(1);
        end else begin
          upd.nxt.rw = 1'b1;
          upd.status = ST_WAIT;
        end
      end
      ACT_WR_ACQ: begin
        if (cur.cnt == '0) begin
          upd.nxt.cnt = CNT_ALL;
        end else begin
          upd.nxt.ww = 1'b1;
          upd.status = ST_WAIT;
        end
      end
      ACT_RD_REL: begin
        if (wlocked || (cur.cnt == '0)) begin
          upd.status = ST_INVALID;
        end else begin
          upd.nxt.cnt = cur.cnt - COUNT_BITS'(1);
          // last reader out: writers take priority
          if (cur.cnt == COUNT_BITS'(1)) begin
            if (cur.ww) begin
              upd.nxt.ww = 1'b0;
              upd.wake_w = 1'b1;
            end else if (cur.rw) begin
              upd.nxt.rw = 1'b0;
              upd.wake_r = 1'b1;
            end
          end
        end
      end
      ACT_WR_REL: begin
        if (!wlocked) begin
          upd.status = ST_INVALID;
        end else begin
          upd.nxt.cnt = '0;
          if (cur.rw) begin
            upd.nxt.rw = 1'b0;
            upd.wake_r = 1'b1;
          end else if (cur.ww) begin
            upd.nxt.ww = 1'b0;
            upd.wake_w = 1'b1;
          end
        end
      end
      ACT_RD_TMO: begin
        upd.status = ST_TIMEOUT;
        if (cur.rw) begin
          upd.nxt.rw = 1'b0;
          upd.wake_r = 1'b1;
          // writers flag stays set, only a wake goes out
          if (!wlocked && cur.ww) begin
            upd.wake_w = 1'b1;
          end
        end
      end
      ACT_WR_TMO: begin
        upd.status = ST_TIMEOUT;
        if (cur.ww) begin
          upd.nxt.ww = 1'b0;
          upd.wake_w = 1'b1;
          if (!wlocked && cur.rw && (cur.cnt == '0)) begin
            upd.wake_r = 1'b1;
          end
        end
      end
      default: begin
        upd.status = ST_INVALID;
      end
    endcase
    upd.nxt.epoch = cur.epoch + EPOCH_BITS'(upd.wake_w);
  end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
  import rwl_pkg::*;

  // action codes the block does not define
  localparam logic [ACT_BITS-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [ACT_BITS-1:0] ACT_SPARE_HI = 3'd7;

  typedef struct packed {
    status_t               status;
    logic                  wake_r;
    logic                  wake_w;
    logic [EPOCH_BITS-1:0] epoch;
    logic [COUNT_BITS-1:0] count;
    logic                  wlocked;
    logic                  rwait;
    logic                  wwait;
  } lock_reply_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [ACT_BITS-1:0]   action;
  logic [ID_BITS-1:0]    lock_id;
  logic                  out_valid;
  logic                  out_stall;
  logic [STAT_BITS-1:0]  status;
  logic                  rd_wake;
  logic                  wr_wake;
  logic [EPOCH_BITS-1:0] writer_epoch;
  logic [COUNT_BITS-1:0] reader_count;
  logic                  write_locked;
  logic                  readers_waiting;
  logic                  writers_waiting;

  lock_state_t lock_table [NUM_LOCKS];
  lock_reply_t pending_replies [$];
  bit          idle_on;
  int          errors;
  int          words_taken;
  int          replies_seen;
  int          writer_wakes;

  reader_writer_lock_table_top dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .action          (action),
    .lock_id         (lock_id),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .rd_wake         (rd_wake),
    .wr_wake         (wr_wake),
    .writer_epoch    (writer_epoch),
    .reader_count    (reader_count),
    .write_locked    (write_locked),
    .readers_waiting (readers_waiting),
    .writers_waiting (writers_waiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("reader_writer_lock_table_top verification failed");
    $finish;
  end

  // updates the lock table for one request and returns the reply it should produce
  function automatic lock_reply_t apply_lock_action(input logic [ACT_BITS-1:0] act,
                                                    input logic [ID_BITS-1:0] id);
    lock_state_t s;
    lock_reply_t r;
    logic        held_w;
    logic        rw0;
    logic        ww0;
    logic [COUNT_BITS-1:0] cnt0;
    s = lock_table[id];
    held_w = (s.cnt == CNT_ALL);
    rw0 = s.rw;
    ww0 = s.ww;
    cnt0 = s.cnt;
    r = '0;
    r.status = ST_OK;
    case (act)
      ACT_RD_ACQ: begin
        if (!ww0 && cnt0 < CNT_ALL - COUNT_BITS'(1)) s.cnt = cnt0 + COUNT_BITS'(1);
        else begin
          s.rw = 1'b1;
          r.status = ST_WAIT;
        end
      end
      ACT_WR_ACQ: begin
        if (cnt0 == 0) s.cnt = CNT_ALL;
        else begin
          s.ww = 1'b1;
          r.status = ST_WAIT;
        end
      end
      ACT_RD_REL: begin
        if (held_w || cnt0 == 0) r.status = ST_INVALID;
        else begin
          s.cnt = cnt0 - COUNT_BITS'(1);
          // last reader out: writers take priority over readers
          if (cnt0 == 1) begin
            if (ww0) begin
              s.ww = 1'b0;
              r.wake_w = 1'b1;
            end else if (rw0) begin
              s.rw = 1'b0;
              r.wake_r = 1'b1;
            end
          end
        end
      end
      ACT_WR_REL: begin
        if (!held_w) r.status = ST_INVALID;
        else begin
          s.cnt = '0;
          if (rw0) begin
            s.rw = 1'b0;
            r.wake_r = 1'b1;
          end else if (ww0) begin
            s.ww = 1'b0;
            r.wake_w = 1'b1;
          end
        end
      end
      ACT_RD_TMO: begin
        r.status = ST_TIMEOUT;
        if (rw0) begin
          s.rw = 1'b0;
          r.wake_r = 1'b1;
          // writers are woken but their flag stays set
          if (!held_w && ww0) r.wake_w = 1'b1;
        end
      end
      ACT_WR_TMO: begin
        r.status = ST_TIMEOUT;
        if (ww0) begin
          s.ww = 1'b0;
          r.wake_w = 1'b1;
          if (!held_w && rw0 && cnt0 == 0) r.wake_r = 1'b1;
        end
      end
      default: r.status = ST_INVALID;
    endcase
    if (r.wake_w) s.epoch = s.epoch + 1'b1;
    lock_table[id] = s;
    r.epoch   = s.epoch;
    r.wlocked = (s.cnt == CNT_ALL);
    r.count   = r.wlocked ? '0 : s.cnt;
    r.rwait   = s.rw;
    r.wwait   = s.ww;
    return r;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // called at a falling edge; returns at a falling edge after the word is taken
  task automatic send_word(input logic [ACT_BITS-1:0] act, input int id);
    int gap;
    in_valid <= 1'b1;
    action   <= act;
    lock_id  <= ID_BITS'(id);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = gap_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      action   <= ACT_BITS'($urandom);
      lock_id  <= ID_BITS'($urandom);
      repeat (gap) @(negedge clk);
    end
  endtask

  // receiver back-pressure
  initial begin : stall_gen
    int hold;
    out_stall = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (!idle_on) begin
        out_stall <= 1'b0;
        hold = 0;
      end else if (hold > 0) begin
        hold--;
      end else if (out_stall) begin
        out_stall <= 1'b0;
        hold = $urandom_range(0, 10);
      end else begin
        out_stall <= 1'b1;
        hold = gap_len();
      end
    end
  end

  always @(posedge clk) begin : scoreboard
    lock_reply_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        replies_seen++;
        if (pending_replies.size() == 0) begin
          errors++;
          $display("%0t: reply with nothing outstanding, status %0d", $time, status);
        end else begin
          want = pending_replies.pop_front();
          check_field("status", 16'(want.status), 16'(status));
          check_field("rd_wake", 16'(want.wake_r), 16'(rd_wake));
          check_field("wr_wake", 16'(want.wake_w), 16'(wr_wake));
          check_field("writer_epoch", want.epoch, writer_epoch);
          check_field("reader_count", 16'(want.count), 16'(reader_count));
          check_field("write_locked", 16'(want.wlocked), 16'(write_locked));
          check_field("readers_waiting", 16'(want.rwait), 16'(readers_waiting));
          check_field("writers_waiting", 16'(want.wwait), 16'(writers_waiting));
        end
      end
      if (in_valid && !in_stall) begin
        words_taken++;
        want = apply_lock_action(action, lock_id);
        if (want.wake_w) writer_wakes++;
        pending_replies.push_back(want);
      end
    end
  end

  task automatic test_acquire_release();
    send_word(ACT_RD_ACQ, 0);
    send_word(ACT_RD_ACQ, 0);
    send_word(ACT_WR_ACQ, 0);   // held by readers, writer queues
    send_word(ACT_RD_ACQ, 0);   // blocked by the waiting writer
    send_word(ACT_RD_REL, 0);
    send_word(ACT_RD_REL, 0);   // last reader out wakes writers
    send_word(ACT_WR_ACQ, 0);
    send_word(ACT_RD_ACQ, 0);
    send_word(ACT_RD_REL, 0);   // release while write locked
    send_word(ACT_WR_REL, 0);   // wakes the waiting readers
    send_word(ACT_WR_REL, 0);   // not write locked
    send_word(ACT_RD_REL, 0);   // no readers held
    send_word(ACT_WR_ACQ, 15);
    send_word(ACT_WR_ACQ, 15);
    send_word(ACT_WR_REL, 15);  // only writers waiting
    send_word(ACT_RD_ACQ, 15);
    send_word(ACT_WR_ACQ, 15);
    send_word(ACT_RD_ACQ, 15);
    send_word(ACT_WR_TMO, 15);
    send_word(ACT_RD_REL, 15);  // last reader out, only readers waiting
  endtask

  task automatic test_timeouts();
    send_word(ACT_WR_ACQ, 7);
    send_word(ACT_WR_ACQ, 7);
    send_word(ACT_RD_ACQ, 7);
    send_word(ACT_RD_TMO, 7);   // write locked, so writers stay asleep
    send_word(ACT_RD_TMO, 7);   // nobody waiting
    send_word(ACT_WR_REL, 7);
    send_word(ACT_RD_ACQ, 7);
    send_word(ACT_RD_TMO, 7);
    send_word(ACT_RD_ACQ, 7);
    send_word(ACT_WR_TMO, 7);
    send_word(ACT_WR_TMO, 7);
    send_word(ACT_RD_TMO, 7);
  endtask

  task automatic test_spare_actions();
    send_word(ACT_SPARE_LO, 3);
    send_word(ACT_SPARE_HI, 15);
    send_word(ACT_WR_ACQ, 3);
    send_word(ACT_SPARE_HI, 3);
    send_word(ACT_SPARE_LO, 3);
    send_word(ACT_WR_REL, 3);
  endtask

  // fill one lock up to the reader ceiling, then time out both sides
  task automatic test_reader_ceiling();
    for (int i = 0; i < int'(CNT_ALL) - 1; i++) send_word(ACT_RD_ACQ, 9);
    send_word(ACT_RD_ACQ, 9);
    send_word(ACT_WR_ACQ, 9);
    send_word(ACT_RD_TMO, 9);
    send_word(ACT_WR_TMO, 9);
  endtask

  function automatic logic [ACT_BITS-1:0] pick_action(input logic [ID_BITS-1:0] id);
    lock_state_t s;
    int r;
    s = lock_table[id];
    r = $urandom_range(0, 99);
    if (r < 12) return ACT_BITS'($urandom_range(0, 7));
    if (s.rw && r < 20) return ACT_RD_TMO;
    if (s.ww && r < 28) return ACT_WR_TMO;
    if (s.cnt == CNT_ALL) return (r < 70) ? ACT_WR_REL : ((r < 85) ? ACT_RD_ACQ : ACT_WR_ACQ);
    if (s.cnt != 0 && r < 60) return ACT_RD_REL;
    return (r < 85) ? ACT_RD_ACQ : ACT_WR_ACQ;
  endfunction

  task automatic test_random_traffic(input int n_words);
    logic [ID_BITS-1:0] id;
    for (int i = 0; i < n_words; i++) begin
      // every third block of 100 words runs with no idling at all
      idle_on = ((i / 100) % 3) != 1;
      if ($urandom_range(0, 99) < 70) id = ID_BITS'($urandom_range(1, 4));
      else id = ID_BITS'($urandom_range(0, NUM_LOCKS - 1));
      send_word(pick_action(id), int'(id));
    end
    idle_on = 1'b1;
  endtask

  initial begin
    int guard;
    rst      = 1'b1;
    in_valid = 1'b0;
    action   = '0;
    lock_id  = '0;
    idle_on  = 1'b1;
    errors   = 0;
    words_taken  = 0;
    replies_seen = 0;
    writer_wakes = 0;
    foreach (lock_table[i]) lock_table[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_acquire_release();
    test_timeouts();
    test_spare_actions();
    test_reader_ceiling();
    test_random_traffic(250);
    in_valid <= 1'b0;

    guard = 0;
    while (pending_replies.size() != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    $display("covered %0d lock requests and %0d replies, %0d of them waking writers,",
             words_taken, replies_seen, writer_wakes);
    $display("including the reader ceiling, every timeout path and the undefined actions");
    if (errors == 0 && pending_replies.size() == 0) begin
      $display("reader_writer_lock_table_top verification clean");
    end else begin
      if (pending_replies.size() != 0)
        $display("%0t: %0d replies never arrived", $time, pending_replies.size());
      $display("reader_writer_lock_table_top verification failed");
    end
    $finish;
  end

endmodule
